// ===== design/bef_pkg.sv =====
// Shared types and constants of the bounded estimate fusion block.
// Used by bef_table, bef_match and bounded_estimate_fusion; no dependencies.
package bef_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int MAX_DIMS_DEF    = 4;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int NUM_COORDS = 4;
  localparam int WEIGHT_W   = 16;
  localparam int SRC_W      = 16;
  localparam int COUNT_W    = 6;
  localparam int BOUND_W    = 15;
  localparam int DIMS_W     = 3;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_DIMS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOUND0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOUND1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOUND2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOUND3 = 3'd4;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;
  localparam logic [SRC_W-1:0]  SRC_MAX    = 16'hFFFF;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

endpackage

// ===== design/bef_table.sv =====
// Entry table of the fusion block: one write port, one read port, registered read data.
// Depends on bef_pkg.
module bef_table
  import bef_pkg::*;
#(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int AW    = 5,
  parameter int EW    = 96
) (
  input  logic          clk_i,
  input  tbl_ctrl_t     ctrl_i,
  input  logic [AW-1:0] raddr_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bef_match.sv =====
// Box match test of one stored entry against the held item, per active dimension.
// Depends on bef_pkg.
module bef_match
  import bef_pkg::*;
#(
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic [MAX_DIMS*COORD_WIDTH-1:0] entry_vec_i,
  input  logic [MAX_DIMS*COORD_WIDTH-1:0] item_vec_i,
  input  logic [MAX_DIMS*BOUND_W-1:0]     bounds_i,
  input  logic [MAX_DIMS-1:0]             active_i,
  output logic                            hit_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = (DW > BOUND_W) ? DW : BOUND_W;

  logic [MAX_DIMS-1:0] ok;

  for (genvar gd = 0; gd < MAX_DIMS; gd++) begin : g_dim
    logic signed [DW-1:0] ev, iv, diff;
    logic [MW-1:0] mag, bnd;
    assign ev   = DW'($signed(entry_vec_i[gd*COORD_WIDTH +: COORD_WIDTH]));
    assign iv   = DW'($signed(item_vec_i[gd*COORD_WIDTH +: COORD_WIDTH]));
    assign diff = ev - iv;
    assign mag  = MW'(diff[DW-1] ? -diff : diff);
    assign bnd  = MW'(bounds_i[gd*BOUND_W +: BOUND_W]);
    assign ok[gd] = !active_i[gd] || (mag <= bnd);
  end

  assign hit_o = &ok;

endmodule

// ===== design/bounded_estimate_fusion.sv =====
// Top level of the bounded estimate fusion block: control, registers, readout.
// Depends on bef_pkg, bef_table and bef_match.
//
// Usage: estimate items enter on in_valid_i/in_ready_o with four signed
// coordinates, a weight and a last_point flag. Each item is matched against
// the stored entries in table order; the first entry inside the per-dimension
// bounds is replaced when the item weighs strictly more; an unmatched item is
// appended, or dropped with a sticky overflow flag when the table is full.
// Between acceptance and its table update an item is scanned through the single
// table read port, one entry a cycle; after an item without last_point the next
// item is accepted in the cycle after the update. On a last_point item every entry
// leaves on out_valid_o/out_ready_i in table order, each read through the read
// port and loaded into the output register before the next read is issued; the
// set then restarts. A stalled receiver holds the output register and the readout
// waits; a finished result waiting does not block the next input item. Reset
// empties the table at once (fill count zero, no clearing pass), sets dims_in_use
// to four and all bounds to zero.
// Configuration is an APB-style port, register i at byte address 4*i.
module bounded_estimate_fusion
  import bef_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] coord_a_i,
  input  logic [COORD_WIDTH-1:0] coord_b_i,
  input  logic [COORD_WIDTH-1:0] coord_c_i,
  input  logic [COORD_WIDTH-1:0] coord_d_i,
  input  logic [WEIGHT_W-1:0]    weight_i,
  input  logic                   last_point_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] out_coord_a_o,
  output logic [COORD_WIDTH-1:0] out_coord_b_o,
  output logic [COORD_WIDTH-1:0] out_coord_c_o,
  output logic [COORD_WIDTH-1:0] out_coord_d_o,
  output logic [WEIGHT_W-1:0]    out_weight_o,
  output logic [SRC_W-1:0]       source_index_o,
  output logic [COUNT_W-1:0]     entry_count_o,
  output logic                   overflowed_o,
  output logic                   last_entry_o
);

  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNW = $clog2(MAX_ENTRIES + 1);
  localparam int CVW = MAX_DIMS * COORD_WIDTH;
  localparam int EW  = CVW + WEIGHT_W + SRC_W;
  localparam logic [CNW-1:0] FILL_MAX = CNW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  // configuration
  logic [DIMS_W-1:0]  dims_q;
  logic [BOUND_W-1:0] bound_q [MAX_DIMS];
  logic [BOUND_W-1:0] bound_rd [NUM_COORDS];
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
      for (int d = 0; d < MAX_DIMS; d++) bound_q[d] <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_DIMS) dims_q <= pwdata[DIMS_W-1:0];
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (cfg_idx == REG_BOUND0 + REG_IDX_W'(d)) bound_q[d] <= pwdata[BOUND_W-1:0];
      end
    end
  end

  for (genvar gd = 0; gd < NUM_COORDS; gd++) begin : g_brd
    if (gd < MAX_DIMS) begin : g_on
      assign bound_rd[gd] = bound_q[gd];
    end else begin : g_off
      assign bound_rd[gd] = '0;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DIMS:   prdata = PDATA_W'(dims_q);
      REG_BOUND0: prdata = PDATA_W'(bound_rd[0]);
      REG_BOUND1: prdata = PDATA_W'(bound_rd[1]);
      REG_BOUND2: prdata = PDATA_W'(bound_rd[2]);
      REG_BOUND3: prdata = PDATA_W'(bound_rd[3]);
      default:    prdata = '0;
    endcase
  end

  // active dimensions and input vector
  logic [DIMS_W-1:0]      nd;
  logic [MAX_DIMS-1:0]    active;
  logic [COORD_WIDTH-1:0] in_coord [NUM_COORDS];
  logic [CVW-1:0]         in_vec;
  logic [MAX_DIMS*BOUND_W-1:0] bounds_flat;

  assign nd = (dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_q;
  assign in_coord[0] = coord_a_i;
  assign in_coord[1] = coord_b_i;
  assign in_coord[2] = coord_c_i;
  assign in_coord[3] = coord_d_i;

  for (genvar gd = 0; gd < MAX_DIMS; gd++) begin : g_in
    assign active[gd] = DIMS_W'(gd) < nd;
    assign in_vec[gd*COORD_WIDTH +: COORD_WIDTH] = active[gd] ? in_coord[gd] : '0;
    assign bounds_flat[gd*BOUND_W +: BOUND_W] = bound_q[gd];
  end

  // control state
  state_e state_q, state_d;
  logic [CNW-1:0]      fill_q, fill_d;
  logic [CNW-1:0]      iss_q, iss_d;
  logic [AW-1:0]       rx_q, rx_d;
  logic                rv_q, rv_d;
  logic [SRC_W-1:0]    pc_q, pc_d;
  logic                ovf_q, ovf_d;

  // held item
  logic [CVW-1:0]      vec_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [SRC_W-1:0]    src_q;
  logic                last_q;

  // output register
  logic                   ov_q, ov_d;
  logic [CVW-1:0]         ovec_q;
  logic [WEIGHT_W-1:0]    ow_q;
  logic [SRC_W-1:0]       osrc_q;
  logic [COUNT_W-1:0]     ocnt_q;
  logic                   oovf_q;
  logic                   olast_q;

  // table interface
  tbl_ctrl_t      tbl_ctrl;
  logic [AW-1:0]  tbl_waddr;
  logic [EW-1:0]  tbl_wdata;
  logic [EW-1:0]  tbl_rdata;
  logic           hit;

  logic [CVW-1:0]      rd_vec;
  logic [WEIGHT_W-1:0] rd_w;
  logic [SRC_W-1:0]    rd_src;

  assign rd_vec = tbl_rdata[CVW-1:0];
  assign rd_w   = tbl_rdata[CVW +: WEIGHT_W];
  assign rd_src = tbl_rdata[CVW+WEIGHT_W +: SRC_W];

  bef_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .EW    (EW)
  ) u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .raddr_i (iss_q[AW-1:0]),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  bef_match #(
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_match (
    .entry_vec_i (rd_vec),
    .item_vec_i  (vec_q),
    .bounds_i    (bounds_flat),
    .active_i    (active),
    .hit_o       (hit)
  );

  logic in_acc, found, miss, decide, dump_load, dump_done, rx_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign found      = (state_q == S_SCAN) && rv_q && hit;
  assign miss       = (state_q == S_SCAN) && !rv_q && (iss_q >= fill_q);
  assign decide     = found || miss;
  assign rx_last    = (CNW'(rx_q) == fill_q - CNW'(1));
  assign dump_load  = (state_q == S_DUMP) && rv_q;
  assign dump_done  = dump_load && rx_last;
  assign tbl_wdata  = {src_q, w_q, vec_q};
  assign tbl_waddr  = found ? rx_q : fill_q[AW-1:0];

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    iss_d    = iss_q;
    rx_d     = rx_q;
    rv_d     = 1'b0;
    pc_d     = pc_q;
    ovf_d    = ovf_q;
    ov_d     = ov_q;
    tbl_ctrl = '0;
    if (out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
          iss_d   = '0;
        end
      end
      S_SCAN: begin
        if (decide) begin
          if (found) begin
            tbl_ctrl.wr_en = w_q > rd_w;
          end else if (fill_q < FILL_MAX) begin
            tbl_ctrl.wr_en = 1'b1;
            fill_d = fill_q + CNW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (pc_q != SRC_MAX) pc_d = pc_q + SRC_W'(1);
          iss_d   = '0;
          state_d = last_q ? S_DUMP : S_IDLE;
        end else if (iss_q < fill_q) begin
          tbl_ctrl.rd_en = 1'b1;
          rv_d  = 1'b1;
          rx_d  = iss_q[AW-1:0];
          iss_d = iss_q + CNW'(1);
        end
      end
      S_DUMP: begin
        if (dump_load) begin
          ov_d = 1'b1;
          if (dump_done) begin
            state_d = S_IDLE;
            fill_d  = '0;
            pc_d    = '0;
            ovf_d   = 1'b0;
          end
        end else if ((!ov_q || out_ready_i) && (iss_q < fill_q)) begin
          tbl_ctrl.rd_en = 1'b1;
          rv_d  = 1'b1;
          rx_d  = iss_q[AW-1:0];
          iss_d = iss_q + CNW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      iss_q   <= '0;
      rx_q    <= '0;
      rv_q    <= 1'b0;
      pc_q    <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      iss_q   <= iss_d;
      rx_q    <= rx_d;
      rv_q    <= rv_d;
      pc_q    <= pc_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vec_q  <= in_vec;
      w_q    <= weight_i;
      src_q  <= pc_q;
      last_q <= last_point_i;
    end
    if (dump_load) begin
      ovec_q  <= rd_vec;
      ow_q    <= rd_w;
      osrc_q  <= rd_src;
      ocnt_q  <= COUNT_W'(fill_q);
      oovf_q  <= ovf_q;
      olast_q <= rx_last;
    end
  end

  logic [COORD_WIDTH-1:0] out_coord [NUM_COORDS];

  for (genvar gd = 0; gd < NUM_COORDS; gd++) begin : g_out
    if (gd < MAX_DIMS) begin : g_on
      assign out_coord[gd] = ovec_q[gd*COORD_WIDTH +: COORD_WIDTH];
    end else begin : g_off
      assign out_coord[gd] = '0;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_coord_a_o  = out_coord[0];
  assign out_coord_b_o  = out_coord[1];
  assign out_coord_c_o  = out_coord[2];
  assign out_coord_d_o  = out_coord[3];
  assign out_weight_o   = ow_q;
  assign source_index_o = osrc_q;
  assign entry_count_o  = ocnt_q;
  assign overflowed_o   = oovf_q;
  assign last_entry_o   = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill count beyond table depth");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_ctrl.wr_en |-> (state_q == S_SCAN) && decide)
    else $error("table written outside an item update");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_load |-> !ov_q)
    else $error("readout entry loaded over a waiting item");

  a_dump_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_done |=> (fill_q == '0) && (pc_q == '0) && !ovf_q && (state_q == S_IDLE))
    else $error("set not restarted after readout");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (fill_q != '0))
    else $error("readout of an empty table");

endmodule

// ===== verif/tb_bounded_estimate_fusion.sv =====
// Self-checking testbench for bounded_estimate_fusion: directed table, clustered random
// estimate sets and a single-entry set, checked against an in-bench fusion predictor or typed entries.
// Depends on bef_pkg and the design sources; no files or arguments are read.
module tb_bounded_estimate_fusion;
  timeunit 1ns;
  timeprecision 1ps;
  import bef_pkg::*;

  localparam int SETTLE = MAX_ENTRIES_DEF + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 50;
  localparam int SAT_ITEMS = 24;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [15:0] wt;
    logic        fin;
  } est_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [15:0] wt;
    logic [15:0] src;
    logic [5:0]  cnt;
    logic        ovf;
    logic        tail;
  } fused_t;

  typedef struct {
    logic [2:0] dims;
    int         bnd[4];
  } setting_t;

  typedef struct {
    int     cfg_sel;
    est_t   est;
    bit     typed;
    fused_t want;
  } drow_t;

  localparam logic [REG_IDX_W-1:0] REG_LIST[5] = '{REG_DIMS, REG_BOUND0, REG_BOUND1,
                                                    REG_BOUND2, REG_BOUND3};

  setting_t dir_set[4] = '{
    '{3'd2, '{3, 32767, 0, 0}},
    '{3'd0, '{0, 0, 0, 0}},
    '{3'd7, '{32767, 32767, 32767, 32767}},
    '{3'd1, '{0, 0, 0, 0}}
  };

  drow_t dir_tab[20] = '{
    '{-1, '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
      '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 6'd1, 1'b0, 1'b1}},
    '{-1, '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}, 1'b1,
      '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 6'd1, 1'b0, 1'b1}},
    '{-1, '{16'h0064, 16'h00C8, 16'h012C, 16'h0190, 16'h000A, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0064, 16'h00C8, 16'h012C, 16'h0190, 16'h000A, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0064, 16'h00C8, 16'h012C, 16'h0190, 16'h000B, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0064, 16'h00C8, 16'h012C, 16'h0190, 16'h0005, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0065, 16'h00C8, 16'h012C, 16'h0190, 16'h0032, 1'b0}, 1'b0, '0},
    '{-1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}, 1'b0, '0},
    '{0, '{16'h0000, 16'h8000, 16'h0007, 16'h0007, 16'h0001, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0003, 16'h7FFF, 16'hFFFB, 16'h0005, 16'h0002, 1'b0}, 1'b0, '0},
    '{-1, '{16'hFFFD, 16'hFFFF, 16'h0009, 16'h0009, 16'h0009, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0064, 1'b1}, 1'b0, '0},
    '{1, '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 1'b0}, 1'b0, '0},
    '{-1, '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0006, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0006, 1'b1}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0006, 16'h0001, 6'd1, 1'b0, 1'b1}},
    '{2, '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b0}, 1'b0, '0},
    '{-1, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0002, 1'b0}, 1'b0, '0},
    '{-1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0003, 1'b0}, 1'b0, '0},
    '{-1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}, 1'b0, '0},
    '{3, '{16'h0007, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b1}, 1'b1,
      '{16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0004, 16'h0000, 6'd1, 1'b0, 1'b1}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [15:0]         coord_a_i = '0;
  logic [15:0]         coord_b_i = '0;
  logic [15:0]         coord_c_i = '0;
  logic [15:0]         coord_d_i = '0;
  logic [15:0]         weight_i = '0;
  logic                last_point_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [15:0]         out_coord_a_o;
  logic [15:0]         out_coord_b_o;
  logic [15:0]         out_coord_c_o;
  logic [15:0]         out_coord_d_o;
  logic [15:0]         out_weight_o;
  logic [15:0]         source_index_o;
  logic [5:0]          entry_count_o;
  logic                overflowed_o;
  logic                last_entry_o;

  int tbl_crd[MAX_ENTRIES_DEF][4];
  logic [15:0] tbl_wt[MAX_ENTRIES_DEF];
  logic [15:0] tbl_src[MAX_ENTRIES_DEF];
  int fill = 0;
  int npts = 0;
  bit set_dropped = 1'b0;
  logic [2:0] cfg_dims = DIMS_RESET;
  int cfg_bnd[4] = '{0, 0, 0, 0};

  fused_t fused_q[$];
  fused_t seen;
  fused_t due;
  int n_pushed = 0;
  int n_err = 0;
  int stall_cycles = 0;
  int rx_hold = 0;
  bit rx_calm = 1'b0;

  bounded_estimate_fusion u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .coord_a_i      (coord_a_i),
    .coord_b_i      (coord_b_i),
    .coord_c_i      (coord_c_i),
    .coord_d_i      (coord_d_i),
    .weight_i       (weight_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_coord_a_o  (out_coord_a_o),
    .out_coord_b_o  (out_coord_b_o),
    .out_coord_c_o  (out_coord_c_o),
    .out_coord_d_o  (out_coord_d_o),
    .out_weight_o   (out_weight_o),
    .source_index_o (source_index_o),
    .entry_count_o  (entry_count_o),
    .overflowed_o   (overflowed_o),
    .last_entry_o   (last_entry_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int draw_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string show_entry(fused_t f);
    return $sformatf("crd %0d %0d %0d %0d wt %0d src %0d cnt %0d ovf %0b last %0b",
                     $signed(f.a), $signed(f.b), $signed(f.c), $signed(f.d),
                     f.wt, f.src, f.cnt, f.ovf, f.tail);
  endfunction

  function automatic void flag_error(string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endfunction

  function automatic void keep_entry(int slot, int v[4], int nd, logic [15:0] wt,
                                     logic [15:0] src);
    for (int d = 0; d < 4; d++) tbl_crd[slot][d] = (d < nd) ? v[d] : 0;
    tbl_wt[slot] = wt;
    tbl_src[slot] = src;
  endfunction

  function automatic void fuse_estimate(est_t e);
    int v[4];
    int nd;
    int hit;
    int diff;
    bit fits;
    logic [15:0] src;
    v[0] = $signed(e.a);
    v[1] = $signed(e.b);
    v[2] = $signed(e.c);
    v[3] = $signed(e.d);
    nd = (cfg_dims > 3'd4) ? 4 : int'(cfg_dims);
    src = 16'(npts);
    hit = -1;
    for (int k = 0; k < fill && hit < 0; k++) begin
      fits = 1'b1;
      for (int d = 0; d < nd; d++) begin
        diff = tbl_crd[k][d] - v[d];
        if (diff < 0) diff = -diff;
        if (diff > cfg_bnd[d]) fits = 1'b0;
      end
      if (fits) hit = k;
    end
    if (hit >= 0) begin
      if (e.wt > tbl_wt[hit]) keep_entry(hit, v, nd, e.wt, src);
    end else if (fill < MAX_ENTRIES_DEF) begin
      keep_entry(fill, v, nd, e.wt, src);
      fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (npts < 65535) npts++;
    if (e.fin) begin
      for (int k = 0; k < fill; k++) begin
        fused_q.push_back('{16'(tbl_crd[k][0]), 16'(tbl_crd[k][1]), 16'(tbl_crd[k][2]),
                            16'(tbl_crd[k][3]), tbl_wt[k], tbl_src[k], 6'(fill),
                            set_dropped, (k == fill - 1)});
        n_pushed++;
      end
      fill = 0;
      npts = 0;
      set_dropped = 1'b0;
    end
  endfunction

  task automatic apb_xfer(bit wr, logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold the sender until every fused entry is out and the last scan has settled, then write and read back the setting
  task automatic apply_setting(setting_t s);
    logic [PDATA_W-1:0] val;
    logic [PDATA_W-1:0] back;
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (fused_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    for (int k = 0; k < 5; k++) begin
      val = (k == 0) ? PDATA_W'(s.dims) : PDATA_W'(s.bnd[k-1]);
      apb_xfer(1'b1, REG_LIST[k], val, back);
    end
    for (int k = 0; k < 5; k++) begin
      val = (k == 0) ? PDATA_W'(s.dims) : PDATA_W'(s.bnd[k-1]);
      apb_xfer(1'b0, REG_LIST[k], '0, back);
      if (back !== val)
        flag_error($sformatf("register %0d readback: want %0h got %0h", k, val, back));
    end
    cfg_dims = s.dims;
    cfg_bnd = s.bnd;
  endtask

  task automatic offer_estimate(est_t e, int gap);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    coord_a_i <= e.a;
    coord_b_i <= e.b;
    coord_c_i <= e.c;
    coord_d_i <= e.d;
    weight_i <= e.wt;
    last_point_i <= e.fin;
    do @(posedge clk_i); while (!in_ready_o);
    fuse_estimate(e);
  endtask

  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= 1'b1;
      rx_hold = draw_gap(rx_calm);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{out_coord_a_o, out_coord_b_o, out_coord_c_o, out_coord_d_o, out_weight_o,
               source_index_o, entry_count_o, overflowed_o, last_entry_o};
      if (fused_q.size() == 0) begin
        flag_error({"unexpected entry: ", show_entry(seen)});
      end else begin
        due = fused_q.pop_front();
        if (seen !== due)
          flag_error({"entry mismatch: want ", show_entry(due), " got ", show_entry(seen)});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("bounded_estimate_fusion test failed");
    $finish;
  end

  initial begin
    setting_t ph;
    est_t e;
    int q_mark;
    int ph_dims[8];
    int spreads[6];
    int ctr[4][4];
    int phase_cnt;
    int set_len;
    int ncent;
    int spread;
    int pick;
    int kind;
    int val;
    bit tx_calm;
    ph_dims = '{4, 1, 0, 3, 7, 2, 4, 5};
    spreads = '{0, 1, 4, 40, 600, 9000};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_sel >= 0) apply_setting(dir_set[dir_tab[i].cfg_sel]);
      q_mark = n_pushed;
      offer_estimate(dir_tab[i].est, draw_gap(1'b0));
      if (dir_tab[i].typed) begin
        repeat (n_pushed - q_mark) void'(fused_q.pop_back());
        fused_q.push_back(dir_tab[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      ph.dims = 3'(ph_dims[p]);
      for (int d = 0; d < 4; d++) begin
        case (p % 4)
          0: ph.bnd[d] = 0;
          1: ph.bnd[d] = 32767;
          2: ph.bnd[d] = $urandom_range(0, 64);
          default: ph.bnd[d] = $urandom_range(0, 32767);
        endcase
      end
      apply_setting(ph);
      phase_cnt = 0;
      while (phase_cnt < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) set_len = $urandom_range(1, 8);
        else if (pick < 90) set_len = $urandom_range(9, 20);
        else set_len = $urandom_range(33, 40);
        ncent = $urandom_range(1, 4);
        spread = spreads[$urandom_range(0, 5)];
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int c = 0; c < 4; c++)
          for (int d = 0; d < 4; d++) ctr[c][d] = int'($urandom_range(0, 65535)) - 32768;
        for (int j = 0; j < set_len; j++) begin
          kind = $urandom_range(0, 99);
          pick = $urandom_range(0, ncent - 1);
          for (int d = 0; d < 4; d++) begin
            if (kind < 75) val = ctr[pick][d] + int'($urandom_range(0, 2 * spread)) - spread;
            else val = $urandom;
            case (d)
              0: e.a = 16'(val);
              1: e.b = 16'(val);
              2: e.c = 16'(val);
              default: e.d = 16'(val);
            endcase
          end
          e.wt = ($urandom_range(0, 99) < 25) ? 16'($urandom) : 16'($urandom_range(0, 15));
          e.fin = (j == set_len - 1);
          offer_estimate(e, draw_gap(tx_calm));
          phase_cnt++;
        end
      end
    end

    // one set on a single entry: every point lands on it and each heavier one takes it over
    apply_setting('{3'd0, '{0, 0, 0, 0}});
    for (int i = 0; i < SAT_ITEMS; i++) begin
      e.a = 16'($urandom);
      e.b = 16'($urandom);
      e.c = 16'($urandom);
      e.d = 16'($urandom);
      e.wt = 16'(i);
      e.fin = (i == SAT_ITEMS - 1);
      offer_estimate(e, 0);
    end

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (fused_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (n_err == 0 && fused_q.size() == 0) begin
      $display("bounded_estimate_fusion test passed");
    end else begin
      $display("bounded_estimate_fusion test failed");
    end
    $finish;
  end

endmodule
